[rtl/cbus_serial_master_defines.svh]
// Assertion macros used by the checker file of the serial bus master.
`ifndef CBUS_SERIAL_MASTER_DEFINES_SVH
`define CBUS_SERIAL_MASTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define CBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/cbm_pkg.sv]
// Types and constants of the serial bus master.
package cbm_pkg;

  localparam int unsigned DevBits  = 3;
  localparam int unsigned RegBits  = 5;
  localparam int unsigned WordBits = 16;
  localparam int unsigned HdrBits  = DevBits + 1 + RegBits;
  localparam int unsigned SendBits = HdrBits + WordBits;
  localparam int unsigned CntBits  = 5;
  localparam int unsigned HpBits   = 16;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEND_LO = 3'd1,
    PH_SEND_HI = 3'd2,
    PH_RECV_LO = 3'd3,
    PH_RECV_HI = 3'd4,
    PH_END_LO  = 3'd5,
    PH_END_HI  = 3'd6
  } phase_e;

  typedef struct packed {
    logic                start_req;
    logic                mode;
    logic [DevBits-1:0]  dev_addr;
    logic [RegBits-1:0]  reg_addr;
    logic [WordBits-1:0] write_data;
    logic                data_pin_in;
  } req_t;

  typedef struct packed {
    logic                clk_pin;
    logic                data_pin_out;
    logic                data_pin_drive;
    logic                sel_pin;
    logic                busy_res;
    logic                done_res;
    logic [WordBits-1:0] read_data;
  } res_t;

endpackage

[rtl/cbm_if.sv]
// Channel interfaces of the serial bus master: configuration, tick input and result.
interface cbm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbm_pkg::HpBits-1:0]  half_period;

  modport source (output valid, output half_period, input ready);
  modport sink (input valid, input half_period, output ready);
endinterface

interface cbm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic                          mode;
  logic [cbm_pkg::DevBits-1:0]   dev_addr;
  logic [cbm_pkg::RegBits-1:0]   reg_addr;
  logic [cbm_pkg::WordBits-1:0]  write_data;
  logic                          data_pin_in;

  modport source (output valid, output start_req, output mode, output dev_addr,
                  output reg_addr, output write_data, output data_pin_in, input ready);
  modport sink (input valid, input start_req, input mode, input dev_addr,
                input reg_addr, input write_data, input data_pin_in, output ready);
endinterface

interface cbm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          clk_pin;
  logic                          data_pin_out;
  logic                          data_pin_drive;
  logic                          sel_pin;
  logic                          busy_res;
  logic                          done_res;
  logic [cbm_pkg::WordBits-1:0]  read_data;

  modport source (output valid, output clk_pin, output data_pin_out, output data_pin_drive,
                  output sel_pin, output busy_res, output done_res, output read_data,
                  input ready);
  modport sink (input valid, input clk_pin, input data_pin_out, input data_pin_drive,
                input sel_pin, input busy_res, input done_res, input read_data,
                output ready);
endinterface

[rtl/cbm_seq.sv]
// Transfer sequencer: phase, tick and bit state, and the line levels of one tick.
module cbm_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [cbm_pkg::HpBits-1:0]  cfg_hp_i,
  input  logic                        acc_i,
  input  cbm_pkg::req_t               req_i,
  output cbm_pkg::res_t               res_o
);

  logic [cbm_pkg::HpBits-1:0]   hp_q;
  logic [cbm_pkg::SendBits-1:0] send_q, send_d, send_e;
  logic [cbm_pkg::WordBits-1:0] recv_q, recv_d, recv_e;
  logic [cbm_pkg::CntBits-1:0]  bits_q, bits_d, bits_e, bits_dec;
  cbm_pkg::phase_e              phase_q, phase_d, phase_e, phase_cur;
  logic [cbm_pkg::HpBits-1:0]   tick_q, tick_d, tick_e;
  logic                         rd_q, rd_d, rd_e;
  logic [cbm_pkg::HpBits-1:0]   hp_eff;
  logic [cbm_pkg::HpBits:0]     tick_inc;
  logic                         start, last;

  always_comb begin
    phase_cur = (phase_q > cbm_pkg::PH_END_HI) ? cbm_pkg::PH_IDLE : phase_q;
    start     = (phase_cur == cbm_pkg::PH_IDLE) && req_i.start_req;

    rd_e    = start ? req_i.mode : rd_q;
    send_e  = start ? {req_i.dev_addr, req_i.mode, req_i.reg_addr,
                       (req_i.mode ? '0 : req_i.write_data)} : send_q;
    recv_e  = start ? '0 : recv_q;
    bits_e  = start ? (req_i.mode ? cbm_pkg::CntBits'(cbm_pkg::HdrBits)
                                  : cbm_pkg::CntBits'(cbm_pkg::SendBits)) : bits_q;
    phase_e = start ? cbm_pkg::PH_SEND_LO : phase_cur;
    tick_e  = start ? '0 : tick_q;

    hp_eff   = (hp_q == '0) ? cbm_pkg::HpBits'(1) : hp_q;
    tick_inc = {1'b0, tick_e} + (cbm_pkg::HpBits+1)'(1);
    last     = tick_inc >= {1'b0, hp_eff};
    bits_dec = bits_e - cbm_pkg::CntBits'(1);

    res_o                = '0;
    res_o.sel_pin        = 1'b1;
    res_o.busy_res       = 1'b1;
    unique case (phase_e)
      cbm_pkg::PH_SEND_LO, cbm_pkg::PH_SEND_HI: begin
        res_o.clk_pin        = (phase_e == cbm_pkg::PH_SEND_HI);
        res_o.data_pin_out   = send_e[cbm_pkg::SendBits-1];
        res_o.data_pin_drive = 1'b1;
        res_o.sel_pin        = 1'b0;
      end
      cbm_pkg::PH_RECV_LO, cbm_pkg::PH_RECV_HI: begin
        res_o.clk_pin = (phase_e == cbm_pkg::PH_RECV_HI);
        res_o.sel_pin = 1'b0;
      end
      cbm_pkg::PH_END_LO: begin
      end
      cbm_pkg::PH_END_HI: begin
        res_o.clk_pin = 1'b1;
      end
      default: begin
        res_o.busy_res = 1'b0;
      end
    endcase

    rd_d    = rd_e;
    send_d  = send_e;
    recv_d  = recv_e;
    bits_d  = bits_e;
    phase_d = phase_e;
    tick_d  = tick_e;
    if (phase_e != cbm_pkg::PH_IDLE) begin
      if (!last) begin
        tick_d = tick_inc[cbm_pkg::HpBits-1:0];
      end else begin
        tick_d = '0;
        unique case (phase_e)
          cbm_pkg::PH_SEND_LO: begin
            phase_d = cbm_pkg::PH_SEND_HI;
          end
          cbm_pkg::PH_SEND_HI: begin
            send_d = {send_e[cbm_pkg::SendBits-2:0], 1'b0};
            bits_d = bits_dec;
            if (bits_dec == '0) begin
              if (rd_e) begin
                bits_d  = cbm_pkg::CntBits'(cbm_pkg::WordBits);
                phase_d = cbm_pkg::PH_RECV_LO;
              end else begin
                phase_d = cbm_pkg::PH_END_LO;
              end
            end else begin
              phase_d = cbm_pkg::PH_SEND_LO;
            end
          end
          cbm_pkg::PH_RECV_LO: begin
            phase_d = cbm_pkg::PH_RECV_HI;
          end
          cbm_pkg::PH_RECV_HI: begin
            recv_d  = {recv_e[cbm_pkg::WordBits-2:0], req_i.data_pin_in};
            bits_d  = bits_dec;
            phase_d = (bits_dec == '0) ? cbm_pkg::PH_END_LO : cbm_pkg::PH_RECV_LO;
          end
          cbm_pkg::PH_END_LO: begin
            phase_d = cbm_pkg::PH_END_HI;
          end
          default: begin
            res_o.done_res  = 1'b1;
            res_o.read_data = rd_e ? recv_e : '0;
            phase_d         = cbm_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= cbm_pkg::HpBits'(1);
    end else if (cfg_we_i) begin
      hp_q <= cfg_hp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q    <= 1'b0;
      send_q  <= '0;
      recv_q  <= '0;
      bits_q  <= '0;
      phase_q <= cbm_pkg::PH_IDLE;
      tick_q  <= '0;
    end else if (acc_i) begin
      rd_q    <= rd_d;
      send_q  <= send_d;
      recv_q  <= recv_d;
      bits_q  <= bits_d;
      phase_q <= phase_d;
      tick_q  <= tick_d;
    end
  end

endmodule

[rtl/cbm_obuf.sv]
// Result register with a skid stage, so a new beat is taken while one waits.
module cbm_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cbm_pkg::res_t data_i,
  output logic          ready_o,
  output logic          valid_o,
  output cbm_pkg::res_t data_o,
  input  logic          ready_i
);

  logic          main_vld_q, main_vld_d, skid_vld_q, skid_vld_d;
  cbm_pkg::res_t main_q, main_d, skid_q, skid_d;

  assign ready_o = !skid_vld_q;
  assign valid_o = main_vld_q;
  assign data_o  = main_q;

  always_comb begin
    main_vld_d = main_vld_q;
    main_d     = main_q;
    skid_vld_d = skid_vld_q;
    skid_d     = skid_q;
    if (!main_vld_q || ready_i) begin
      if (skid_vld_q) begin
        main_vld_d = 1'b1;
        main_d     = skid_q;
        skid_vld_d = 1'b0;
      end else begin
        main_vld_d = push_i;
        main_d     = data_i;
      end
    end else if (push_i) begin
      skid_vld_d = 1'b1;
      skid_d     = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      main_vld_q <= main_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

endmodule

[rtl/cbus_serial_master.sv]
// Three-wire serial bus master driven by one tick per input beat. Every accepted
// beat is one tick and yields exactly one result beat with the clock, data, select
// and status levels of that tick; a beat can be taken every cycle while the buffer
// has room, and its result is registered there. The sequencer state is updated
// once per accepted beat, and a two-entry result buffer keeps input beats flowing
// while a result waits. Write half_period only while no transfer is running.
module cbus_serial_master (
  input  logic         clk_i,
  input  logic         rst_ni,
  cbm_cfg_if.sink      cfg_i,
  cbm_in_if.sink       in_i,
  cbm_out_if.source    out_o
);

  cbm_pkg::req_t req;
  cbm_pkg::res_t res, res_out;
  logic          acc, buf_ready;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = buf_ready;
  assign acc         = in_i.valid && buf_ready;

  assign req.start_req   = in_i.start_req;
  assign req.mode        = in_i.mode;
  assign req.dev_addr    = in_i.dev_addr;
  assign req.reg_addr    = in_i.reg_addr;
  assign req.write_data  = in_i.write_data;
  assign req.data_pin_in = in_i.data_pin_in;

  cbm_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_we_i (cfg_i.valid),
    .cfg_hp_i (cfg_i.half_period),
    .acc_i    (acc),
    .req_i    (req),
    .res_o    (res)
  );

  cbm_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_o.valid),
    .data_o  (res_out),
    .ready_i (out_o.ready)
  );

  assign out_o.clk_pin        = res_out.clk_pin;
  assign out_o.data_pin_out   = res_out.data_pin_out;
  assign out_o.data_pin_drive = res_out.data_pin_drive;
  assign out_o.sel_pin        = res_out.sel_pin;
  assign out_o.busy_res       = res_out.busy_res;
  assign out_o.done_res       = res_out.done_res;
  assign out_o.read_data      = res_out.read_data;

endmodule

[rtl/cbm_checker.sv]
// Port checker for the serial bus master and its bind to the top level.
`include "cbus_serial_master_defines.svh"

module cbm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         clk_pin_i,
  input logic                         data_pin_out_i,
  input logic                         data_pin_drive_i,
  input logic                         sel_pin_i,
  input logic                         busy_res_i,
  input logic                         done_res_i,
  input logic [cbm_pkg::WordBits-1:0] read_data_i
);

  logic [cbm_pkg::WordBits+5:0] levels;
  logic                         stalled, done_ok, idle_ok;

  assign levels  = {clk_pin_i, data_pin_out_i, data_pin_drive_i, sel_pin_i, busy_res_i,
                    done_res_i, read_data_i};
  assign stalled = out_valid_i && !out_ready_i;
  assign done_ok = busy_res_i && sel_pin_i && clk_pin_i && !data_pin_drive_i;
  assign idle_ok = !clk_pin_i && sel_pin_i && !data_pin_drive_i && !done_res_i;

  `CBM_ASSERT_NEXT(a_out_hold, stalled, out_valid_i && $stable(levels), "result changed in stall")
  `CBM_ASSERT_NOW(a_done_busy, out_valid_i && done_res_i, done_ok, "done beat with wrong levels")
  `CBM_ASSERT_NOW(a_released, out_valid_i && !data_pin_drive_i, !data_pin_out_i, "released line high")
  `CBM_ASSERT_NOW(a_idle_lines, out_valid_i && !busy_res_i, idle_ok, "idle beat with active lines")
  `CBM_ASSERT_NOW(a_rdata_zero, out_valid_i && !done_res_i, read_data_i == '0, "stray read word")

endmodule

bind cbus_serial_master cbm_checker u_cbm_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .clk_pin_i        (out_o.clk_pin),
  .data_pin_out_i   (out_o.data_pin_out),
  .data_pin_drive_i (out_o.data_pin_drive),
  .sel_pin_i        (out_o.sel_pin),
  .busy_res_i       (out_o.busy_res),
  .done_res_i       (out_o.done_res),
  .read_data_i      (out_o.read_data)
);
